/* hw/rtl/sira_pkg.sv */
// Shared types, constants and helpers for the signed integer to radix ASCII converter.
// No dependencies; used by sira_div_unit, the top level and the checker.
package sira_pkg;

    // Default input width
    localparam int VALUE_BITS_DEF = 32;

    // Restoring divide steps applied per clock by the shared divider
    localparam int DIV_STEPS = 8;

    localparam int BASE_W  = 5;
    localparam int DIGIT_W = 4;
    localparam int CHAR_W  = 8;

    localparam logic [BASE_W-1:0] BASE_MIN   = 5'd2;
    localparam logic [BASE_W-1:0] BASE_MAX   = 5'd16;
    localparam logic [BASE_W-1:0] BASE_DEC   = 5'd10;
    localparam logic [BASE_W-1:0] BASE_RESET = 5'd10;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_A     = 8'h41;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SIGN,
        ST_READ,
        ST_EMIT
    } state_t;

    // Sequencer to divider
    typedef struct packed {
        logic load;   // take a new dividend
        logic run;    // advance one group of divide steps
    } div_ctrl_t;

    // Divider to sequencer
    typedef struct packed {
        logic               digit_done;  // remainder valid this cycle
        logic [DIGIT_W-1:0] digit;       // remainder of the current division
        logic               quot_zero;   // quotient of this division is zero
    } div_stat_t;

    // Digit 0..15 to '0'-'9', 'A'-'F'
    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] d_ext;
        d_ext = CHAR_W'(d);
        if (d < DIGIT_W'(BASE_DEC)) begin
            return CHAR_ZERO + d_ext;
        end else begin
            return CHAR_A + (d_ext - CHAR_W'(BASE_DEC));
        end
    endfunction

endpackage

/* hw/rtl/sira_div_unit.sv */
// Shared iterative divider: divides the held value by a small radix, several
// restoring steps per clock. Depends on sira_pkg.
module sira_div_unit #(
    parameter int VALUE_BITS = sira_pkg::VALUE_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  sira_pkg::div_ctrl_t               ctrl,
    input  logic [VALUE_BITS-1:0]             load_value,
    input  logic [sira_pkg::BASE_W-1:0]       base,
    output sira_pkg::div_stat_t               stat
);

    localparam int STEPS      = sira_pkg::DIV_STEPS;
    localparam int DIV_CYCLES = (VALUE_BITS + STEPS - 1) / STEPS;
    localparam int PAD_BITS   = DIV_CYCLES * STEPS;
    localparam int CYC_W      = $clog2(DIV_CYCLES + 1);
    localparam int DW         = sira_pkg::DIGIT_W;
    localparam int BW         = sira_pkg::BASE_W;

    logic [PAD_BITS-1:0] quot_reg, quot_next;
    logic [DW-1:0]       rem_reg,  rem_next;
    logic [CYC_W-1:0]    step_reg, step_next;

    logic [PAD_BITS-1:0] q_work;
    logic [DW-1:0]       r_work;
    logic [BW-1:0]       t_work;
    logic                last_group;

    // Restoring steps: remainder stays below the radix, so it is narrow
    always_comb begin
        q_work = quot_reg;
        r_work = rem_reg;
        t_work = '0;
        for (int i = 0; i < STEPS; i++) begin
            t_work = {r_work, q_work[PAD_BITS-1]};
            q_work = {q_work[PAD_BITS-2:0], 1'b0};
            if (t_work >= base) begin
                t_work    = t_work - base;
                q_work[0] = 1'b1;
            end
            r_work = t_work[DW-1:0];
        end
    end

    assign last_group = (step_reg == CYC_W'(DIV_CYCLES - 1));

    // Next state of the divider
    always_comb begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        if (ctrl.load) begin
            quot_next = PAD_BITS'(load_value);
            rem_next  = '0;
            step_next = '0;
        end else if (ctrl.run) begin
            quot_next = q_work;
            if (last_group) begin
                rem_next  = '0;
                step_next = '0;
            end else begin
                rem_next  = r_work;
                step_next = step_reg + CYC_W'(1);
            end
        end
    end

    // Step counter is control; quotient and remainder are payload
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
        end else begin
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign stat.digit_done = ctrl.run && last_group;
    assign stat.digit      = r_work;
    assign stat.quot_zero  = (q_work == '0);

endmodule

/* hw/rtl/signed_int_to_radix_ascii_top.sv */
// Top level of the signed integer to radix ASCII converter.
// Depends on sira_pkg and sira_div_unit.
//
// Takes one signed integer per item and returns its text in the radix held in
// the digit base register (2 to 16, reset 10; writes below 2 store 2, above 16
// store 16), one ASCII character per output item, most significant digit
// first, '-' leading only for negative values in radix 10, m_is_last on the
// final character. The block works on one number at a time and s_ready is low
// until its last character is taken. The shared divider resolves 8 quotient
// bits per clock, and each character is first read from the registered digit
// store and then presented on the output.
module signed_int_to_radix_ascii_top #(
    parameter int VALUE_BITS = sira_pkg::VALUE_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration
    input  logic                               cfg_wr_en,
    input  logic [sira_pkg::BASE_W-1:0]        cfg_wr_data,
    // input items
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [VALUE_BITS-1:0]       s_value,
    // result items
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [sira_pkg::CHAR_W-1:0]        m_out_char,
    output logic                               m_is_last
);

    localparam int CNT_W = $clog2(VALUE_BITS + 1);
    localparam int AW    = $clog2(VALUE_BITS);
    localparam int DW    = sira_pkg::DIGIT_W;
    localparam int BW    = sira_pkg::BASE_W;

    sira_pkg::state_t state_reg, state_next;

    logic [BW-1:0]    base_reg,  base_next;
    logic             minus_reg, minus_next;
    logic [CNT_W-1:0] cnt_reg,   cnt_next;
    logic [AW-1:0]    ptr_reg,   ptr_next;

    logic [DW-1:0]    digit_mem [VALUE_BITS];
    logic [DW-1:0]    rd_data_reg;
    logic             mem_we;

    logic [VALUE_BITS-1:0] raw_value;
    logic [VALUE_BITS-1:0] mag_value;
    logic                  in_accept;
    logic                  conv_done;

    sira_pkg::div_ctrl_t div_ctrl;
    sira_pkg::div_stat_t div_stat;

    // Magnitude of the input; the most negative value maps to 2^(VALUE_BITS-1)
    assign raw_value = $unsigned(s_value);
    assign mag_value = raw_value[VALUE_BITS-1]
                     ? (~raw_value + VALUE_BITS'(1)) : raw_value;

    assign in_accept = s_valid && s_ready;

    sira_div_unit #(
        .VALUE_BITS (VALUE_BITS)
    ) u_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (div_ctrl),
        .load_value (mag_value),
        .base       (base_reg),
        .stat       (div_stat)
    );

    // Radix register with clamping on write
    always_comb begin
        base_next = base_reg;
        if (cfg_wr_en) begin
            if (cfg_wr_data < sira_pkg::BASE_MIN) begin
                base_next = sira_pkg::BASE_MIN;
            end else if (cfg_wr_data > sira_pkg::BASE_MAX) begin
                base_next = sira_pkg::BASE_MAX;
            end else begin
                base_next = cfg_wr_data;
            end
        end
    end

    // Conversion ends on a zero quotient or a full digit store
    assign conv_done = div_stat.digit_done
                    && (div_stat.quot_zero
                        || ((cnt_reg + CNT_W'(1)) == CNT_W'(VALUE_BITS)));

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        minus_next    = minus_reg;
        cnt_next      = cnt_reg;
        ptr_next      = ptr_reg;
        div_ctrl.load = 1'b0;
        div_ctrl.run  = 1'b0;
        mem_we        = 1'b0;
        s_ready       = 1'b0;
        m_valid       = 1'b0;
        m_out_char    = sira_pkg::digit_to_ascii(rd_data_reg);
        m_is_last     = 1'b0;
        unique case (state_reg)
            sira_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (in_accept) begin
                    div_ctrl.load = 1'b1;
                    minus_next    = raw_value[VALUE_BITS-1]
                                 && (base_reg == sira_pkg::BASE_DEC);
                    cnt_next      = '0;
                    state_next    = sira_pkg::ST_DIV;
                end
            end
            sira_pkg::ST_DIV: begin
                div_ctrl.run = 1'b1;
                if (div_stat.digit_done) begin
                    mem_we   = 1'b1;
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                if (conv_done) begin
                    ptr_next   = cnt_reg[AW-1:0];
                    state_next = minus_reg ? sira_pkg::ST_SIGN : sira_pkg::ST_READ;
                end
            end
            sira_pkg::ST_SIGN: begin
                m_valid    = 1'b1;
                m_out_char = sira_pkg::CHAR_MINUS;
                if (m_ready) begin
                    state_next = sira_pkg::ST_READ;
                end
            end
            sira_pkg::ST_READ: begin
                state_next = sira_pkg::ST_EMIT;
            end
            sira_pkg::ST_EMIT: begin
                m_valid   = 1'b1;
                m_is_last = (ptr_reg == '0);
                if (m_ready) begin
                    if (ptr_reg == '0) begin
                        state_next = sira_pkg::ST_IDLE;
                    end else begin
                        ptr_next   = ptr_reg - AW'(1);
                        state_next = sira_pkg::ST_READ;
                    end
                end
            end
            default: begin
                state_next = sira_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sira_pkg::ST_IDLE;
            base_reg  <= sira_pkg::BASE_RESET;
            minus_reg <= 1'b0;
            cnt_reg   <= '0;
            ptr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            base_reg  <= base_next;
            minus_reg <= minus_next;
            cnt_reg   <= cnt_next;
            ptr_reg   <= ptr_next;
        end
    end

    // Digit store, least significant digit at entry 0, registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            digit_mem[cnt_reg[AW-1:0]] <= div_stat.digit;
        end
        rd_data_reg <= digit_mem[ptr_reg];
    end

endmodule

/* hw/rtl/sira_checker.sv */
// Port-level checker for the signed integer to radix ASCII converter, bound to
// the top level. Depends on sira_pkg.
module sira_checker #(
    parameter int VALUE_BITS = sira_pkg::VALUE_BITS_DEF
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          cfg_wr_en,
    input logic [sira_pkg::BASE_W-1:0]   cfg_wr_data,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic [VALUE_BITS-1:0]         s_value,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [sira_pkg::CHAR_W-1:0]   m_out_char,
    input logic                          m_is_last
);

    // A stalled output item holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_char) && $stable(m_is_last))
        else $error("output item changed while stalled");

    // No new number is taken while characters are being delivered
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while output valid");

    // An accepted number keeps the input closed on the next cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after accept");

    // Delivery of the last character reopens the input
    a_idle_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_is_last |=> s_ready && !m_valid)
        else $error("block not idle after last character");

    // The sign never ends a number
    a_sign_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_out_char == sira_pkg::CHAR_MINUS) |-> !m_is_last)
        else $error("minus sign flagged as last character");

endmodule

bind signed_int_to_radix_ascii_top sira_checker #(
    .VALUE_BITS (VALUE_BITS)
) u_sira_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_value     (s_value),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_out_char  (m_out_char),
    .m_is_last   (m_is_last)
);

/* tb/signed_int_to_radix_ascii_top_test.sv */
// Self-checking testbench for signed_int_to_radix_ascii_top: random and directed integers
// go in, the ASCII text that comes out is compared with the text predicted in the bench.
// Depends on sira_pkg and the RTL of the converter.
module signed_int_to_radix_ascii_top_test;

    localparam int QUIET_LIMIT = 3000;       // cycles with no handshake before giving up
    localparam int LONG_HOLD   = 250;        // long result stall, in cycles
    localparam logic [127:0] GLYPHS = "0123456789ABCDEF";

    typedef struct packed {
        logic [sira_pkg::CHAR_W-1:0] ch;
        logic                        last;
    } text_char_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          cfg_wr_en = 1'b0;
    logic [sira_pkg::BASE_W-1:0]   cfg_wr_data = '0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic [31:0]                   s_value = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic [sira_pkg::CHAR_W-1:0]   m_out_char;
    logic                          m_is_last;

    logic [31:0]                   pending_values[$];
    text_char_t                    expected_text[$];
    logic [sira_pkg::BASE_W-1:0]   radix_setting = sira_pkg::BASE_RESET;
    int                            items_accepted = 0;
    int                            errors = 0;
    int                            burst_left = 0;
    int                            gap_left = 0;
    int                            hold_left = 0;
    bit                            long_hold_done = 0;
    int                            ready_mode = 0;
    logic [15:0]                   pattern_cycle = '0;
    int                            quiet_cycles = 0;

    signed_int_to_radix_ascii_top dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_value    (s_value),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_char (m_out_char),
        .m_is_last  (m_is_last)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Text of one integer in the given radix, most significant digit first
    function automatic void predict_text(input logic [31:0] v,
                                         input logic [sira_pkg::BASE_W-1:0] radix);
        logic [31:0] mag;
        logic [3:0]  digits[0:31];
        int          n;
        text_char_t  c;
        mag = v[31] ? (~v + 32'd1) : v;   // most negative value stays 2^31
        n = 0;
        do begin
            digits[n] = 4'(mag % radix);
            mag = mag / radix;
            n++;
        end while (mag != 0);
        if (v[31] && radix == sira_pkg::BASE_DEC) begin
            c.ch = sira_pkg::CHAR_MINUS;
            c.last = 1'b0;
            expected_text.push_back(c);
        end
        for (int k = n - 1; k >= 0; k--) begin
            c.ch = GLYPHS[8 * (15 - digits[k]) +: 8];
            c.last = (k == 0);
            expected_text.push_back(c);
        end
    endfunction

    // Radix write, only once every queued number is fully out
    task automatic set_digit_base(input logic [sira_pkg::BASE_W-1:0] raw);
        while (pending_values.size() != 0 || s_valid || expected_text.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= raw;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (raw < sira_pkg::BASE_MIN) begin
            radix_setting = sira_pkg::BASE_MIN;
        end else if (raw > sira_pkg::BASE_MAX) begin
            radix_setting = sira_pkg::BASE_MAX;
        end else begin
            radix_setting = raw;
        end
    endtask

    // Input driver: bursts of items with random gaps
    always @(posedge aclk) begin : item_driver
        logic offer;
        offer = 1'b0;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_text(s_value, radix_setting);
                items_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_values.size() != 0) begin
                    s_value <= pending_values.pop_front();
                    offer = 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 8);
                        case ($urandom_range(0, 3))
                            0, 1: gap_left = 0;
                            2: gap_left = $urandom_range(1, 6);
                            default: gap_left = $urandom_range(10, 80);
                        endcase
                    end else begin
                        burst_left--;
                    end
                end
                s_valid <= offer;
            end
        end
    end

    // Result checker and ready pattern
    always @(posedge aclk) begin : result_monitor
        text_char_t want;
        logic       rdy;
        rdy = 1'b1;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_text.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected char %h (last %b)", $time, m_out_char, m_is_last);
                end else begin
                    want = expected_text.pop_front();
                    if (m_out_char !== want.ch) begin
                        errors++;
                        $display("%0t: out_char expected %h got %h", $time, want.ch, m_out_char);
                    end
                    if (m_is_last !== want.last) begin
                        errors++;
                        $display("%0t: is_last expected %b got %b", $time, want.last, m_is_last);
                    end
                end
            end
            pattern_cycle++;
            if (pattern_cycle[5:0] == 6'd0)
                ready_mode = $urandom_range(0, 3);
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (!long_hold_done && s_valid && !s_ready && items_accepted >= 30) begin
                // long stall while the sender is blocked behind a busy block
                hold_left = LONG_HOLD;
                long_hold_done = 1;
                rdy = 1'b0;
            end else begin
                case (ready_mode)
                    0: rdy = 1'b1;
                    1: rdy = 1'($urandom_range(0, 1));
                    2: rdy = (pattern_cycle[2:0] < 3'd3);
                    default: rdy = ($urandom_range(0, 5) == 0);
                endcase
            end
            m_ready <= rdy;
        end
    end

    // Watchdog on cycles with no handshake on either side
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Stimulus
    initial begin : stimulus
        logic [31:0] v;
        logic [31:0] small_max;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // reset radix 10: sign, zero, extremes
        pending_values.push_back(32'd0);
        pending_values.push_back(32'd1);
        pending_values.push_back(32'hFFFF_FFFF);
        pending_values.push_back(32'd9);
        pending_values.push_back(32'd10);
        pending_values.push_back(-32'sd10);
        pending_values.push_back(32'h7FFF_FFFF);
        pending_values.push_back(32'h8000_0000);
        pending_values.push_back(-32'sd987654321);

        // radix 16: negative values lose their sign
        set_digit_base(5'd16);
        pending_values.push_back(32'hFFFF_FFFF);
        pending_values.push_back(32'hDEAD_BEEF);
        pending_values.push_back(32'h7FFF_FFFF);
        pending_values.push_back(32'h8000_0000);
        pending_values.push_back(32'd255);

        // radix 2: longest texts
        set_digit_base(5'd2);
        pending_values.push_back(32'h8000_0000);
        pending_values.push_back(32'h7FFF_FFFF);
        pending_values.push_back(32'd5);
        pending_values.push_back(32'd0);

        // out of range writes clamp to 2 or 16; then in-range radixes 7 and 3
        set_digit_base(5'd0);
        pending_values.push_back(32'd6);
        set_digit_base(5'd31);
        pending_values.push_back(32'h00AB_CDEF);
        set_digit_base(5'd1);
        pending_values.push_back(32'd3);
        set_digit_base(5'd17);
        pending_values.push_back(-32'sd16);
        set_digit_base(5'd7);
        pending_values.push_back(-32'sd49);
        pending_values.push_back(32'd342391);
        set_digit_base(5'd3);
        pending_values.push_back(32'h8000_0000);

        // random radixes and values
        for (int p = 0; p < 8; p++) begin
            set_digit_base(sira_pkg::BASE_W'($urandom_range(0, 31)));
            small_max = 32'(radix_setting) * radix_setting * radix_setting;
            for (int i = 0; i < 9; i++) begin
                case ($urandom_range(0, 5))
                    0: v = $urandom;
                    1: v = $urandom_range(0, small_max);
                    2: v = -$urandom_range(0, 1000);
                    3: begin
                        case ($urandom_range(0, 5))
                            0: v = 32'd0;
                            1: v = 32'd1;
                            2: v = 32'hFFFF_FFFF;
                            3: v = 32'h7FFF_FFFF;
                            4: v = 32'h8000_0000;
                            default: v = 32'h8000_0001;
                        endcase
                    end
                    4: v = 32'd1 << $urandom_range(0, 31);
                    default: begin
                        v = $urandom >> $urandom_range(0, 31);
                        if ($urandom_range(0, 1))
                            v = -v;
                    end
                endcase
                pending_values.push_back(v);
            end
        end

        // drain, then let any stray output show up
        while (pending_values.size() != 0 || s_valid || expected_text.size() != 0)
            @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
